[hw/rtl/mte_pkg.sv]
// Shared types, codes and the Morse symbol table of the Morse timing encoder.
package mte_pkg;

    localparam int NUM_REGS = 6;

    // Element kinds. Each kind's duration lives in the register of the same index.
    localparam logic [2:0] KIND_DOT      = 3'd0;
    localparam logic [2:0] KIND_DASH     = 3'd1;
    localparam logic [2:0] KIND_SYM_GAP  = 3'd2;
    localparam logic [2:0] KIND_CHAR_GAP = 3'd3;
    localparam logic [2:0] KIND_WORD_GAP = 3'd4;
    localparam logic [2:0] KIND_SENT_GAP = 3'd5;

    localparam logic [7:0] REG_RESET [NUM_REGS] = '{8'd1, 8'd3, 8'd1, 8'd3, 8'd7, 8'd10};

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_EXCL    = 8'h21;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [5:0] DIGIT_BASE = 6'd26;

    // Symbol pattern: bit i set means the i-th symbol sent is a dash.
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] code;
    } t_morse;

    typedef struct packed {
        logic load;   // take the accepted character into the sequence registers
        logic step;   // move the next element into the output register
    } t_cmd;

    typedef struct packed {
        logic pending;   // elements of the current character remain
        logic out_free;  // output register is empty or drains this cycle
    } t_status;

    // Index 0..25 are letters A..Z, 26..35 are digits 0..9.
    function automatic t_morse morse_lookup(input logic [5:0] idx);
        t_morse m;
        unique case (idx)
            6'd0:  m = '{3'd2, 5'b00010};
            6'd1:  m = '{3'd4, 5'b00001};
            6'd2:  m = '{3'd4, 5'b00101};
            6'd3:  m = '{3'd3, 5'b00001};
            6'd4:  m = '{3'd1, 5'b00000};
            6'd5:  m = '{3'd4, 5'b00100};
            6'd6:  m = '{3'd3, 5'b00011};
            6'd7:  m = '{3'd4, 5'b00000};
            6'd8:  m = '{3'd2, 5'b00000};
            6'd9:  m = '{3'd4, 5'b01110};
            6'd10: m = '{3'd3, 5'b00101};
            6'd11: m = '{3'd4, 5'b00010};
            6'd12: m = '{3'd2, 5'b00011};
            6'd13: m = '{3'd2, 5'b00001};
            6'd14: m = '{3'd3, 5'b00111};
            6'd15: m = '{3'd4, 5'b00110};
            6'd16: m = '{3'd4, 5'b01011};
            6'd17: m = '{3'd3, 5'b00010};
            6'd18: m = '{3'd3, 5'b00000};
            6'd19: m = '{3'd1, 5'b00001};
            6'd20: m = '{3'd3, 5'b00100};
            6'd21: m = '{3'd4, 5'b01000};
            6'd22: m = '{3'd3, 5'b00110};
            6'd23: m = '{3'd4, 5'b01001};
            6'd24: m = '{3'd4, 5'b01101};
            6'd25: m = '{3'd4, 5'b00011};
            6'd26: m = '{3'd5, 5'b11111};
            6'd27: m = '{3'd5, 5'b11110};
            6'd28: m = '{3'd5, 5'b11100};
            6'd29: m = '{3'd5, 5'b11000};
            6'd30: m = '{3'd5, 5'b10000};
            6'd31: m = '{3'd5, 5'b00000};
            6'd32: m = '{3'd5, 5'b00001};
            6'd33: m = '{3'd5, 5'b00011};
            6'd34: m = '{3'd5, 5'b00111};
            6'd35: m = '{3'd5, 5'b01111};
            default: m = '{3'd0, 5'b00000};
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/morse_timing_encoder_core.sv]
// Morse timing encoder top level: one ASCII character in, its timing elements out.
//
// Input channel: i_in_valid / o_in_ready carry one character per transfer.
// Output channel: o_out_valid / i_out_ready carry one element per transfer,
// with its duration, kind and a last flag on the final element of a character.
// Letters and digits give their dots and dashes with symbol gaps between them,
// preceded by a character gap when the previous character was alphanumeric.
// Whitespace gives one word gap, terminal punctuation one sentence gap, and
// other characters give nothing (they still clear the previous-alphanumeric flag).
// The character is loaded into the sequence registers, then each of its elements moves on to the output register.
// The sequencer emits one element per cycle into a single output register while that register is free.
// A stalled receiver holds the output register and pauses the sequencer; the
// next character is taken once the last element has moved to the output register.
// Reset restores the duration registers to their defaults and clears the flag.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) take effect at once.
module morse_timing_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_character,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_wait_units,
    output logic [2:0] o_element_kind,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_data
);
    import mte_pkg::*;

    t_cmd    cmd;
    t_status sts;

    mte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mte_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_character    (i_character),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_wait_units   (o_wait_units),
        .o_element_kind (o_element_kind),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step && o_in_ready |-> 1'b0)
        else $error("element issued while accepting a character");
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step ##1 !sts.pending |=> o_in_ready)
        else $error("input not reopened after the final element");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_element_kind <= KIND_SENT_GAP)
        else $error("element kind out of range");
`endif

endmodule

[hw/rtl/mte_ctrl.sv]
// Controller state machine of the Morse timing encoder.
module mte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mte_pkg::t_status i_sts,
    output mte_pkg::t_cmd    o_cmd
);
    import mte_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.pending) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> i_sts.out_free && i_sts.pending)
        else $error("element issued without room or without pending work");
    a_idle_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_sts.pending)
        else $error("ready for a character while elements remain");
    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_RUN && !o_in_ready)
        else $error("controller did not start after a transfer");
`endif

endmodule

[hw/rtl/mte_dpath.sv]
// Datapath of the Morse timing encoder: decode, element sequencing, registers, output stage.
module mte_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_character,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_addr,
    input  logic [7:0]       i_cfg_data,
    input  mte_pkg::t_cmd    i_cmd,
    output mte_pkg::t_status o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_wait_units,
    output logic [2:0]       o_element_kind,
    output logic             o_last
);
    import mte_pkg::*;

    logic [7:0] r_cfg [NUM_REGS];

    // Sequence registers for the character being sent.
    logic       r_prev_alnum, n_prev_alnum;
    logic       r_gp, n_gp;        // word or sentence gap pending
    logic [2:0] r_gk, n_gk;
    logic       r_cg, n_cg;        // character gap pending
    logic       r_sg, n_sg;        // symbol gap before the next symbol
    logic [4:0] r_code, n_code;
    logic [2:0] r_rem, n_rem;

    logic       r_out_valid;
    logic [7:0] r_out_units;
    logic [2:0] r_out_kind;
    logic       r_out_last;

    logic       is_alnum, is_ws, is_punct;
    logic [5:0] sym_idx;
    logic [7:0] ch_off;
    t_morse     sym;
    logic [2:0] el_kind;
    logic       el_last;

    always_comb begin
        is_alnum = 1'b0;
        is_ws    = 1'b0;
        is_punct = 1'b0;
        ch_off   = 8'd0;
        sym_idx  = 6'd0;
        case (i_character) inside
            [CH_UPPER_A:CH_UPPER_Z]: begin
                is_alnum = 1'b1;
                ch_off   = i_character - CH_UPPER_A;
                sym_idx  = ch_off[5:0];
            end
            [CH_LOWER_A:CH_LOWER_Z]: begin
                is_alnum = 1'b1;
                ch_off   = i_character - CH_LOWER_A;
                sym_idx  = ch_off[5:0];
            end
            [CH_DIGIT_0:CH_DIGIT_9]: begin
                is_alnum = 1'b1;
                ch_off   = i_character - CH_DIGIT_0;
                sym_idx  = DIGIT_BASE + ch_off[5:0];
            end
            CH_SPACE, CH_TAB, CH_LF:     is_ws    = 1'b1;
            CH_PERIOD, CH_EXCL, CH_QUEST: is_punct = 1'b1;
            default: ;
        endcase
    end

    assign sym = morse_lookup(sym_idx);

    // Next element, in priority order of what is still owed.
    always_comb begin
        if (r_gp) begin
            el_kind = r_gk;
            el_last = 1'b1;
        end else if (r_cg) begin
            el_kind = KIND_CHAR_GAP;
            el_last = 1'b0;
        end else if (r_sg) begin
            el_kind = KIND_SYM_GAP;
            el_last = 1'b0;
        end else begin
            el_kind = r_code[0] ? KIND_DASH : KIND_DOT;
            el_last = (r_rem == 3'd1);
        end
    end

    always_comb begin
        n_prev_alnum = r_prev_alnum;
        n_gp   = r_gp;
        n_gk   = r_gk;
        n_cg   = r_cg;
        n_sg   = r_sg;
        n_code = r_code;
        n_rem  = r_rem;
        if (i_cmd.load) begin
            n_prev_alnum = is_alnum;
            n_gp   = is_ws || is_punct;
            n_gk   = is_ws ? KIND_WORD_GAP : KIND_SENT_GAP;
            n_cg   = is_alnum && r_prev_alnum;
            n_sg   = 1'b0;
            n_code = sym.code;
            n_rem  = is_alnum ? sym.len : 3'd0;
        end else if (i_cmd.step) begin
            if (r_gp) begin
                n_gp = 1'b0;
            end else if (r_cg) begin
                n_cg = 1'b0;
            end else if (r_sg) begin
                n_sg = 1'b0;
            end else begin
                n_code = r_code >> 1;
                n_rem  = r_rem - 3'd1;
                n_sg   = (r_rem > 3'd1);
            end
        end
    end

    assign o_sts.pending  = r_gp || r_cg || r_sg || (r_rem != 3'd0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alnum <= 1'b0;
            r_gp  <= 1'b0;
            r_cg  <= 1'b0;
            r_sg  <= 1'b0;
            r_rem <= 3'd0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= REG_RESET[k];
            end
        end else begin
            r_prev_alnum <= n_prev_alnum;
            r_gp  <= n_gp;
            r_cg  <= n_cg;
            r_sg  <= n_sg;
            r_rem <= n_rem;
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && ({29'd0, i_cfg_addr} < NUM_REGS)) begin
                r_cfg[i_cfg_addr] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gk   <= n_gk;
        r_code <= n_code;
        if (i_cmd.step) begin
            r_out_units <= r_cfg[el_kind];
            r_out_kind  <= el_kind;
            r_out_last  <= el_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wait_units   = r_out_units;
    assign o_element_kind = r_out_kind;
    assign o_last         = r_out_last;

endmodule

[bench/morse_timing_encoder_core_tb.sv]
// Self-checking testbench for the Morse timing encoder core, with its own element predictor.
module morse_timing_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    // Register indexes of the configuration port; 6 and 7 are unused.
    localparam logic [2:0] REG_DOT       = 3'd0;
    localparam logic [2:0] REG_DASH      = 3'd1;
    localparam logic [2:0] REG_SYM_GAP   = 3'd2;
    localparam logic [2:0] REG_CHAR_GAP  = 3'd3;
    localparam logic [2:0] REG_WORD_GAP  = 3'd4;
    localparam logic [2:0] REG_SENT_GAP  = 3'd5;
    localparam logic [2:0] REG_SPARE_6   = 3'd6;
    localparam logic [2:0] REG_SPARE_7   = 3'd7;

    localparam logic [7:0] DUR_DEFAULT [NUM_REGS] = '{8'd1, 8'd3, 8'd1, 8'd3, 8'd7, 8'd10};

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 46;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 60;

    typedef struct packed {
        logic [7:0] units;
        logic [2:0] kind;
        logic       last;
    } t_element;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_character = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_wait_units;
    logic [2:0] o_element_kind;
    logic       o_last;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_addr = 3'd0;
    logic [7:0] i_cfg_data = 8'h00;

    logic [7:0] pending_chars [$];
    t_element   expected_elems [$];
    logic [7:0] dur_reg [NUM_REGS];
    logic       prev_alnum;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    morse_timing_encoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_character    (i_character),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_wait_units   (o_wait_units),
        .o_element_kind (o_element_kind),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Letters A..Z at 0..25, digits 0..9 at 26..35.
    function automatic string morse_pattern(input int idx);
        case (idx)
            0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
            4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
            8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
            12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
            16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
            20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
            24: return "-.--";  25: return "--..";
            26: return "-----"; 27: return ".----"; 28: return "..---"; 29: return "...--";
            30: return "....-"; 31: return "....."; 32: return "-...."; 33: return "--...";
            34: return "---.."; 35: return "----.";
            default: return "";
        endcase
    endfunction

    task automatic push_element(input logic [2:0] elem_kind);
        expected_elems.push_back('{units: dur_reg[elem_kind], kind: elem_kind, last: 1'b0});
    endtask

    // Appends the timing run of one accepted character to the expected elements.
    task automatic predict_timing_run(input logic [7:0] ch);
        string    pat;
        int       first;
        t_element tail;
        pat = "";
        first = expected_elems.size();
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            pat = morse_pattern(int'(ch - CH_UPPER_A));
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            pat = morse_pattern(int'(ch - CH_LOWER_A));
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            pat = morse_pattern(26 + int'(ch - CH_DIGIT_0));
        end
        if (pat.len() != 0) begin
            if (prev_alnum) begin
                push_element(KIND_CHAR_GAP);
            end
            for (int i = 0; i < pat.len(); i++) begin
                if (i != 0) begin
                    push_element(KIND_SYM_GAP);
                end
                push_element(pat[i] == "-" ? KIND_DASH : KIND_DOT);
            end
            prev_alnum = 1'b1;
        end else begin
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) begin
                push_element(KIND_WORD_GAP);
            end else if (ch == CH_PERIOD || ch == CH_EXCL || ch == CH_QUEST) begin
                push_element(KIND_SENT_GAP);
            end
            // Any non-alphanumeric, dropped or not, breaks the run of alphanumerics.
            prev_alnum = 1'b0;
        end
        if (expected_elems.size() > first) begin
            tail = expected_elems.pop_back();
            tail.last = 1'b1;
            expected_elems.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Character sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                void'(pending_chars.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the current transfer until it is taken.
            end else if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_character <= pending_chars[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Register shadow, prediction at input transfers and checking at output transfers.
    always @(posedge i_clk) begin
        t_element want;
        if (!i_rst_n) begin
            foreach (dur_reg[r]) dur_reg[r] = DUR_DEFAULT[r];
            prev_alnum = 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr <= REG_SENT_GAP) begin
                dur_reg[i_cfg_addr] = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                predict_timing_run(i_character);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_elems.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"%0t ns: element with nothing expected, ",
                                  "actual units %0d kind %0d last %0d"},
                                 $time, o_wait_units, o_element_kind, o_last);
                    end
                end else begin
                    want = expected_elems.pop_front();
                    if (o_wait_units !== want.units) begin
                        report_mismatch("wait_units", want.units, o_wait_units);
                    end
                    if (o_element_kind !== want.kind) begin
                        report_mismatch("element_kind", want.kind, o_element_kind);
                    end
                    if (o_last !== want.last) begin
                        report_mismatch("last", want.last, o_last);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every character is taken and every element is back, then lets
    // the sequencer finish any trailing dropped character.
    task automatic wait_until_idle();
        while (pending_chars.size() != 0 || i_in_valid || expected_elems.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly text that reaches the alphanumeric paths, with some arbitrary bytes.
    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(25));
        end else if (r < 55) begin
            return CH_DIGIT_0 + 8'($urandom_range(9));
        end else if (r < 68) begin
            case ($urandom_range(2))
                0: return CH_SPACE;
                1: return CH_TAB;
                default: return CH_LF;
            endcase
        end else if (r < 78) begin
            case ($urandom_range(2))
                0: return CH_PERIOD;
                1: return CH_EXCL;
                default: return CH_QUEST;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] duration_for_phase(input int phase);
        case (phase)
            0: return 8'd255;
            1: return 8'd1;
            4: return $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial begin
        logic [7:0] opening_text [] = '{
            "A", "z", "Z", "a", "0", "9", CH_SPACE, "E", CH_TAB, CH_LF, "T", CH_PERIOD,
            CH_EXCL, CH_QUEST, "K", 8'h00, "M", 8'hFF, 8'h80, "7", 8'h5B, "8", 8'h40,
            8'h60, 8'h7B
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_text[k]) pending_chars.push_back(opening_text[k]);
        wait_until_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            for (int r = REG_DOT; r <= REG_SENT_GAP; r++) begin
                write_reg(3'(r), duration_for_phase(phase));
            end
            write_reg(phase[0] ? REG_SPARE_7 : REG_SPARE_6, 8'($urandom_range(255)));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            repeat (ITEMS_PER_PHASE) pending_chars.push_back(random_char());
            wait_until_idle();
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
